@@ rtl/core/sprite_span_decoder_unit_macros.svh @@
// Assertion macros for the sprite span decoder.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef SPRITE_SPAN_DECODER_UNIT_MACROS_SVH
`define SPRITE_SPAN_DECODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sprite span decoder check failed");
`define SSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sprite span decoder check failed");
`else
`define SSD_ASSERT_IMP(lbl, ante, cons)
`define SSD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/ssd_pkg.sv @@
// Sprite span decoder package: payload types, item kinds, register indexes.
// No dependencies.
package ssd_pkg;

  localparam logic [1:0] KIND_FRAME_START = 2'd0;
  localparam logic [1:0] KIND_ROW_HEADER  = 2'd1;
  localparam logic [1:0] KIND_ROW_DATA    = 2'd2;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

  localparam logic [15:0] FRAME_WIDTH_RESET  = 16'd1;
  localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd1;

  localparam logic [8:0] SPAN_HEAD_BYTES = 9'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] row_bytes;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_address;
    logic [7:0]  pixel_value;
    logic        span_error;
  } out_item_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [15:0]            value;
  } cfg_write_t;

endpackage

@@ rtl/core/ssd_stream_if.sv @@
// Valid/ready channel carrying one payload of type T per transaction.
// Payload types come from ssd_pkg.
interface ssd_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/sprite_span_decoder_unit.sv @@
// Sprite span decoder top level: skip/count run-length rows to pixel writes.
// Depends on ssd_pkg, ssd_stream_if and sprite_span_decoder_unit_macros.svh.
//
// Channels: item_i takes frame start, row header and row data items;
// result_o gives pixel writes and span error reports; cfg_i writes
// frame_width (index 0) and frame_height (index 1), always ready.
// Each transaction on item_i is decoded in the cycle it is accepted;
// a resulting write goes to the result register, or to the skid buffer
// while a result waits. Throughput: one item per cycle while item_i.ready
// is high, set by the span decoder state update feeding the result register.
// The result register is backed by a one-entry skid buffer, so an item is
// still taken while a result waits. item_i.ready drops only while the skid
// entry is occupied, i.e. after the receiver has stalled with a result
// pending and another result was produced.
// Reset clears decoder state and both output entries, and sets frame_width
// and frame_height to 1.
`include "sprite_span_decoder_unit_macros.svh"

module sprite_span_decoder_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  ssd_stream_if.sink   item_i,
  ssd_stream_if.source result_o,
  ssd_stream_if.sink   cfg_i
);

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_COUNT,
    PH_LITERAL
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] row_left_q, row_left_d;
  logic [31:0] cursor_q, cursor_d;
  logic [7:0]  lit_left_q, lit_left_d;
  logic [31:0] row_base_q, row_base_d;
  logic        row_seen_q, row_seen_d;
  logic [15:0] frame_width_q, frame_width_d;
  logic [15:0] frame_height_q, frame_height_d;

  logic                 out_valid_q, out_valid_d;
  ssd_pkg::out_item_t   out_q, out_d;
  logic                 skid_valid_q, skid_valid_d;
  ssd_pkg::out_item_t   skid_q, skid_d;

  ssd_pkg::in_item_t    item;
  ssd_pkg::cfg_write_t  cfg;
  ssd_pkg::out_item_t   res;
  logic                 res_valid;
  logic                 accept;
  logic                 pop;
  logic [31:0]          limit;
  logic [8:0]           used;
  logic [7:0]           lit_dec;

  assign item   = item_i.data;
  assign cfg    = cfg_i.data;
  assign accept = item_i.valid && item_i.ready;
  assign pop    = out_valid_q && result_o.ready;
  assign limit  = {16'd0, frame_width_q} * {16'd0, frame_height_q};
  assign used   = {1'b0, item.data_byte} + ssd_pkg::SPAN_HEAD_BYTES;
  assign lit_dec = lit_left_q - 8'd1;

  assign item_i.ready   = !skid_valid_q;
  assign cfg_i.ready    = 1'b1;
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    if (cfg_i.valid) begin
      case (cfg.index)
        ssd_pkg::REG_FRAME_WIDTH:  frame_width_d  = cfg.value;
        ssd_pkg::REG_FRAME_HEIGHT: frame_height_d = cfg.value;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d    = phase_q;
    row_left_d = row_left_q;
    cursor_d   = cursor_q;
    lit_left_d = lit_left_q;
    row_base_d = row_base_q;
    row_seen_d = row_seen_q;
    res_valid  = 1'b0;
    res        = '0;
    if (accept) begin
      case (item.kind)
        ssd_pkg::KIND_FRAME_START: begin
          phase_d    = PH_SKIP;
          row_left_d = '0;
          cursor_d   = '0;
          lit_left_d = '0;
          row_base_d = '0;
          row_seen_d = 1'b0;
        end
        ssd_pkg::KIND_ROW_HEADER: begin
          row_base_d = row_seen_q ? row_base_q + {16'd0, frame_width_q} : 32'd0;
          row_seen_d = 1'b1;
          cursor_d   = row_base_d;
          row_left_d = item.row_bytes;
          lit_left_d = '0;
          phase_d    = PH_SKIP;
        end
        ssd_pkg::KIND_ROW_DATA: begin
          case (phase_q)
            PH_SKIP: begin
              if (row_left_q >= {7'd0, ssd_pkg::SPAN_HEAD_BYTES}) begin
                cursor_d = cursor_q + {24'd0, item.data_byte};
                if ({8'd0, item.data_byte} >= frame_width_q) begin
                  row_left_d     = '0;
                  res_valid      = 1'b1;
                  res.span_error = 1'b1;
                end else begin
                  phase_d = PH_COUNT;
                end
              end
            end
            PH_COUNT: begin
              row_left_d = (row_left_q > {7'd0, used}) ? row_left_q - {7'd0, used} : 16'd0;
              lit_left_d = item.data_byte;
              phase_d    = (item.data_byte != 8'd0) ? PH_LITERAL : PH_SKIP;
            end
            PH_LITERAL: begin
              if (cursor_q < limit) begin
                res_valid         = 1'b1;
                res.pixel_address = cursor_q;
                res.pixel_value   = item.data_byte;
              end
              cursor_d   = cursor_q + 32'd1;
              lit_left_d = lit_dec;
              if (lit_dec == 8'd0) begin
                phase_d = PH_SKIP;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = res_valid;
        out_d       = res;
      end
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_SKIP;
      row_left_q     <= '0;
      cursor_q       <= '0;
      lit_left_q     <= '0;
      row_base_q     <= '0;
      row_seen_q     <= 1'b0;
      frame_width_q  <= ssd_pkg::FRAME_WIDTH_RESET;
      frame_height_q <= ssd_pkg::FRAME_HEIGHT_RESET;
      out_valid_q    <= 1'b0;
      out_q          <= '0;
      skid_valid_q   <= 1'b0;
      skid_q         <= '0;
    end else begin
      phase_q        <= phase_d;
      row_left_q     <= row_left_d;
      cursor_q       <= cursor_d;
      lit_left_q     <= lit_left_d;
      row_base_q     <= row_base_d;
      row_seen_q     <= row_seen_d;
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
      out_valid_q    <= out_valid_d;
      out_q          <= out_d;
      skid_valid_q   <= skid_valid_d;
      skid_q         <= skid_d;
    end
  end

  `SSD_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q)
  `SSD_ASSERT_IMP(a_literal_has_count, phase_q == PH_LITERAL, lit_left_q != 8'd0)
  `SSD_ASSERT_IMP(a_error_zero_payload, out_valid_q && out_q.span_error,
                  out_q.pixel_address == 32'd0 && out_q.pixel_value == 8'd0)
  `SSD_ASSERT_NXT(a_frame_start_clears, accept && item.kind == ssd_pkg::KIND_FRAME_START,
                  !row_seen_q && cursor_q == 32'd0 && phase_q == PH_SKIP)

endmodule
